// ===== rtl/core/ccwb_pkg.sv =====
`default_nettype none
package ccwb_pkg;
    localparam int BUFFER_DEPTH = 10;
    localparam int MAX_ERASE = 10;
    localparam int LBA_COUNT = 128;
    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    localparam logic [1:0] CMD_READ = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_ERASE = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    localparam logic [2:0] K_ACCEPT = 3'd0;
    localparam logic [2:0] K_REJECT = 3'd1;
    localparam logic [2:0] K_RDATA = 3'd2;
    localparam logic [2:0] K_RMISS = 3'd3;
    localparam logic [2:0] K_FWRITE = 3'd4;
    localparam logic [2:0] K_FERASE = 3'd5;
    localparam logic [2:0] K_FDONE = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  lba;
        logic [31:0] data_value;
        logic [3:0]  erase_size;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  out_lba;
        logic [31:0] out_data;
        logic [3:0]  out_size;
        logic        out_last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_INSERT,
        ST_APPEND,
        ST_FLUSH,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/coalescing_command_write_buffer_top.sv =====
// Coalescing write buffer in front of flash, holding up to BUFFER_DEPTH
// pending write and erase commands.
// Input channel in/in_valid/in_ready carries one command per transaction;
// output channel out/out_valid/out_ready carries its results, the final one
// flagged by out_last.
// One command is handled at a time: in_ready is high only when idle, so it
// stays low from acceptance until the last result has been taken.
// A read walks the stored entries, one entry a cycle, and then offers its
// result in the output register. An insert walks and compacts the same
// way, then appends, and offers its accept.
// A flush, or an insert that fills the buffer, then emits one entry per
// result transaction, count+1 results in all.
// Each result waits in the output register while the receiver stalls;
// the walk resumes once it is taken.
// Reset empties the buffer (count to zero); entry storage is not cleared.
`default_nettype none
module coalescing_command_write_buffer_top (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ccwb_pkg::in_item_t  in,
    input  wire                 in_valid,
    output logic                in_ready,
    output ccwb_pkg::out_item_t out,
    output logic                out_valid,
    input  wire                 out_ready
);
    import ccwb_pkg::*;

    logic              mem_erase [BUFFER_DEPTH];
    logic [7:0]        mem_addr  [BUFFER_DEPTH];
    logic [31:0]       mem_pay   [BUFFER_DEPTH];

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  wr_reg, wr_next;
    in_item_t          cmd_reg, cmd_next;
    logic [7:0]        nl_reg, nl_next;
    logic [31:0]       ns_reg, ns_next;
    logic              hit_reg, hit_next;
    logic [31:0]       val_reg, val_next;
    out_item_t         out_reg, out_next;

    logic              we;
    logic [IDX_W-1:0]  wa;
    logic              wd_erase;
    logic [7:0]        wd_addr;
    logic [31:0]       wd_pay;

    logic              e_er;
    logic [7:0]        e_a;
    logic [31:0]       e_p;
    logic [8:0]        ol, nl9, oe, ne;
    logic              keep;
    logic [7:0]        nl_c;
    logic [31:0]       ns_c;
    logic [8:0]        chk_end;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_erase[wa] <= wd_erase;
            mem_addr[wa]  <= wd_addr;
            mem_pay[wa]   <= wd_pay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg  <= rd_next;
        wr_reg  <= wr_next;
        cmd_reg <= cmd_next;
        nl_reg  <= nl_next;
        ns_reg  <= ns_next;
        hit_reg <= hit_next;
        val_reg <= val_next;
        out_reg <= out_next;
    end

    // current entry under the walk
    always_comb
    begin
        e_er = mem_erase[rd_reg[IDX_W-1:0]];
        e_a  = mem_addr[rd_reg[IDX_W-1:0]];
        e_p  = mem_pay[rd_reg[IDX_W-1:0]];
        ol   = {1'b0, e_a};
        nl9  = {1'b0, nl_reg};
        oe   = ol + {5'd0, e_p[3:0]};
        ne   = nl9 + {5'd0, ns_reg[3:0]};
        keep = 1'b1;
        nl_c = nl_reg;
        ns_c = ns_reg;
        if (!e_er)
        begin
            if (cmd_reg.cmd != CMD_ERASE)
                keep = (e_a != nl_reg);
            else
                keep = !(nl9 <= ol && ne > ol);
        end
        else if (cmd_reg.cmd == CMD_ERASE)
        begin
            if (ol > nl9)
            begin
                if (ne >= ol)
                begin
                    if (ne >= oe)
                        keep = 1'b0;
                    else if (oe - nl9 <= 9'(MAX_ERASE))
                    begin
                        ns_c = 32'(oe - nl9);
                        keep = 1'b0;
                    end
                end
            end
            else if (oe >= nl9)
            begin
                if (oe >= ne)
                begin
                    nl_c = e_a;
                    ns_c = e_p;
                    keep = 1'b0;
                end
                else if (ne - ol <= 9'(MAX_ERASE))
                begin
                    ns_c = 32'(ne - ol);
                    nl_c = e_a;
                    keep = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        count_next = count_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        cmd_next   = cmd_reg;
        nl_next    = nl_reg;
        ns_next    = ns_reg;
        hit_next   = hit_reg;
        val_next   = val_reg;
        out_next   = out_reg;
        we         = 1'b0;
        wa         = wr_reg[IDX_W-1:0];
        wd_erase   = e_er;
        wd_addr    = e_a;
        wd_pay     = e_p;
        in_ready   = (state_reg == ST_IDLE);
        out_valid  = (state_reg == ST_OUT);
        out        = out_reg;
        chk_end    = {1'b0, in.lba} + {5'd0, in.erase_size};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = in;
                    rd_next  = '0;
                    wr_next  = '0;
                    hit_next = 1'b0;
                    val_next = '0;
                    nl_next  = in.lba;
                    ns_next  = (in.cmd == CMD_ERASE) ? {28'd0, in.erase_size} : in.data_value;
                    out_next = '0;
                    out_next.out_last = 1'b1;
                    if (in.cmd == CMD_FLUSH)
                        state_next = ST_FLUSH;
                    else if ({1'b0, in.lba} >= 9'(LBA_COUNT))
                    begin
                        out_next.out_kind = K_REJECT;
                        ret_next   = ST_IDLE;
                        state_next = ST_OUT;
                    end
                    else if (in.cmd == CMD_READ)
                        state_next = ST_READ;
                    else if (in.cmd == CMD_ERASE && (in.erase_size == 4'd0
                             || in.erase_size > 4'(MAX_ERASE)
                             || chk_end > 9'(LBA_COUNT)))
                    begin
                        out_next.out_kind = K_REJECT;
                        ret_next   = ST_IDLE;
                        state_next = ST_OUT;
                    end
                    else
                        state_next = ST_INSERT;
                end
            end
            ST_READ:
            begin
                if (rd_reg < count_reg)
                begin
                    if (!e_er)
                    begin
                        if (e_a == cmd_reg.lba)
                        begin
                            hit_next = 1'b1;
                            val_next = e_p;
                        end
                    end
                    else if (e_a <= cmd_reg.lba
                             && ol + {5'd0, e_p[3:0]} > {1'b0, cmd_reg.lba})
                    begin
                        hit_next = 1'b1;
                        val_next = 32'h0000_0000;
                    end
                    rd_next = rd_reg + 1'b1;
                end
                else
                begin
                    out_next.out_kind = hit_reg ? K_RDATA : K_RMISS;
                    out_next.out_lba  = cmd_reg.lba;
                    out_next.out_data = hit_reg ? val_reg : 32'd0;
                    out_next.out_last = 1'b1;
                    ret_next   = ST_IDLE;
                    state_next = ST_OUT;
                end
            end
            ST_INSERT:
            begin
                // compaction in place: write index never passes read index
                if (rd_reg < count_reg)
                begin
                    nl_next = nl_c;
                    ns_next = ns_c;
                    if (keep)
                    begin
                        we      = 1'b1;
                        wr_next = wr_reg + 1'b1;
                    end
                    rd_next = rd_reg + 1'b1;
                end
                else
                    state_next = ST_APPEND;
            end
            ST_APPEND:
            begin
                if (wr_reg < CNT_W'(BUFFER_DEPTH))
                begin
                    we       = 1'b1;
                    wd_erase = (cmd_reg.cmd == CMD_ERASE);
                    wd_addr  = nl_reg;
                    wd_pay   = ns_reg;
                    count_next = wr_reg + 1'b1;
                end
                else
                    count_next = wr_reg;
                out_next = '0;
                out_next.out_kind = K_ACCEPT;
                if (wr_reg >= CNT_W'(BUFFER_DEPTH - 1))
                begin
                    out_next.out_last = 1'b0;
                    rd_next  = '0;
                    ret_next = ST_FLUSH;
                end
                else
                begin
                    out_next.out_last = 1'b1;
                    ret_next = ST_IDLE;
                end
                state_next = ST_OUT;
            end
            ST_FLUSH:
            begin
                out_next = '0;
                if (rd_reg < count_reg)
                begin
                    out_next.out_lba = e_a;
                    if (e_er)
                    begin
                        out_next.out_kind = K_FERASE;
                        out_next.out_size = e_p[3:0];
                    end
                    else
                    begin
                        out_next.out_kind = K_FWRITE;
                        out_next.out_data = e_p;
                    end
                    rd_next  = rd_reg + 1'b1;
                    ret_next = ST_FLUSH;
                end
                else
                begin
                    out_next.out_kind = K_FDONE;
                    out_next.out_last = 1'b1;
                    count_next = '0;
                    ret_next   = ST_IDLE;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ret_reg;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/ccwb_checker.sv =====
`default_nettype none
module ccwb_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_ready,
    input ccwb_pkg::out_item_t out,
    input wire                 out_valid,
    input wire                 out_ready
);
    import ccwb_pkg::*;

    // one transaction at a time: no input taken while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output active together");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out))
        else $error("stalled result changed");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out.out_kind == K_FDONE |-> out.out_last)
        else $error("flush done without last");

    a_acc_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready after acceptance");
endmodule

bind coalescing_command_write_buffer_top ccwb_checker u_ccwb_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out(out), .out_valid(out_valid), .out_ready(out_ready)
);
`default_nettype wire

// ===== sim/ccwb_checker.sv =====
`timescale 1ns / 100ps
module ccwb_tb_checker
    import ccwb_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  in_item_t  in,
    input  wire       in_valid,
    input  wire       in_ready,
    input  out_item_t out,
    input  wire       out_valid,
    input  wire       out_ready,
    output int        fail_count,
    output int        pending,
    output int        result_count
);
    // buffered flash commands, oldest first
    logic        buf_erase [BUFFER_DEPTH];
    logic [8:0]  buf_addr  [BUFFER_DEPTH];
    logic [31:0] buf_pay   [BUFFER_DEPTH];
    int          buf_n;

    out_item_t   expected_results[$];

    initial
    begin
        fail_count   = 0;
        result_count = 0;
        buf_n        = 0;
    end

    assign pending = expected_results.size();

    task automatic report_mismatch(input string what);
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
            fail_count++;
        end
    endtask

    task automatic add_result(input out_item_t r);
        begin
            expected_results = {expected_results, r};
        end
    endtask

    function automatic out_item_t mk(input logic [2:0] kind, input logic [7:0] lba,
                                     input logic [31:0] data, input logic [3:0] size);
        out_item_t r;
        begin
            r.out_kind = kind;
            r.out_lba  = lba;
            r.out_data = data;
            r.out_size = size;
            r.out_last = 1'b0;
            return r;
        end
    endfunction

    task automatic emit_flush();
        int i;
        begin
            for (i = 0; i < buf_n; i++)
            begin
                if (buf_erase[i])
                    add_result(mk(K_FERASE, buf_addr[i][7:0], 0, buf_pay[i][3:0]));
                else
                    add_result(mk(K_FWRITE, buf_addr[i][7:0], buf_pay[i], 0));
            end
            buf_n = 0;
            add_result(mk(K_FDONE, 0, 0, 0));
        end
    endtask

    task automatic coalesce(input logic is_er, input int lba, input logic [31:0] arg);
        logic        ke [BUFFER_DEPTH];
        int          ka [BUFFER_DEPTH];
        logic [31:0] kp [BUFFER_DEPTH];
        int          n, i, nl, ns, ol, op, oe, ne;
        logic        keep;
        begin
            n  = 0;
            nl = lba;
            ns = int'(arg);
            for (i = 0; i < buf_n; i++)
            begin
                keep = 1'b1;
                ol   = buf_addr[i];
                op   = int'(buf_pay[i]);
                if (!buf_erase[i])
                begin
                    if (!is_er) keep = (ol != nl);
                    else        keep = !(nl <= ol && nl + ns > ol);
                end
                else if (is_er)
                begin
                    oe = ol + op;
                    ne = nl + ns;
                    if (ol > nl)
                    begin
                        if (ne >= ol)
                        begin
                            if (ne >= oe) keep = 1'b0;
                            else if (oe - nl <= MAX_ERASE)
                            begin
                                ns   = oe - nl;
                                keep = 1'b0;
                            end
                        end
                    end
                    else if (oe >= nl)
                    begin
                        if (oe >= ne)
                        begin
                            nl   = ol;
                            ns   = op;
                            keep = 1'b0;
                        end
                        else if (ne - ol <= MAX_ERASE)
                        begin
                            ns   = ne - ol;
                            nl   = ol;
                            keep = 1'b0;
                        end
                    end
                end
                if (keep)
                begin
                    ke[n] = buf_erase[i];
                    ka[n] = ol;
                    kp[n] = buf_pay[i];
                    n++;
                end
            end
            if (n < BUFFER_DEPTH)
            begin
                ke[n] = is_er;
                ka[n] = nl;
                kp[n] = is_er ? 32'(ns) : arg;
                n++;
            end
            for (i = 0; i < n; i++)
            begin
                buf_erase[i] = ke[i];
                buf_addr[i]  = 9'(ka[i]);
                buf_pay[i]   = kp[i];
            end
            buf_n = n;
        end
    endtask

    task automatic predict_command(input in_item_t c);
        int          i, lba, sz;
        logic        hit;
        logic [31:0] val;
        begin
            lba   = c.lba;
            sz    = c.erase_size;
            if (c.cmd == CMD_FLUSH)
                emit_flush();
            else if (lba >= LBA_COUNT)
                add_result(mk(K_REJECT, 0, 0, 0));
            else if (c.cmd == CMD_READ)
            begin
                hit = 1'b0;
                val = 0;
                for (i = 0; i < buf_n; i++)
                begin
                    if (!buf_erase[i])
                    begin
                        if (buf_addr[i] == lba)
                        begin
                            hit = 1'b1;
                            val = buf_pay[i];
                        end
                    end
                    else if (buf_addr[i] <= lba && buf_addr[i] + buf_pay[i] > lba)
                    begin
                        hit = 1'b1;
                        val = 0;
                    end
                end
                add_result(mk(hit ? K_RDATA : K_RMISS, c.lba, val, 0));
            end
            else if (c.cmd == CMD_ERASE &&
                     (sz == 0 || sz > MAX_ERASE || lba + sz > LBA_COUNT))
                add_result(mk(K_REJECT, 0, 0, 0));
            else
            begin
                coalesce(c.cmd == CMD_ERASE, lba,
                         c.cmd == CMD_ERASE ? 32'(sz) : c.data_value);
                add_result(mk(K_ACCEPT, 0, 0, 0));
                if (buf_n >= BUFFER_DEPTH) emit_flush();
            end
            expected_results[expected_results.size() - 1].out_last = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n)
        begin
            if (in_valid && in_ready) predict_command(in);
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %p", out));
                else
                begin
                    e = expected_results.pop_front();
                    if (out.out_kind !== e.out_kind)
                        report_mismatch($sformatf("kind %0d, want %0d", out.out_kind,
                                                  e.out_kind));
                    if (out.out_lba !== e.out_lba)
                        report_mismatch($sformatf("lba %0d, want %0d", out.out_lba,
                                                  e.out_lba));
                    if (out.out_data !== e.out_data)
                        report_mismatch($sformatf("data %h, want %h", out.out_data,
                                                  e.out_data));
                    if (out.out_size !== e.out_size)
                        report_mismatch($sformatf("size %0d, want %0d", out.out_size,
                                                  e.out_size));
                    if (out.out_last !== e.out_last)
                        report_mismatch($sformatf("last %0b, want %0b", out.out_last,
                                                  e.out_last));
                end
            end
        end
    end
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import ccwb_pkg::*;

    localparam int N_RANDOM  = 390;
    localparam int MAX_CYCLE = 400000;

    logic      clk;
    logic      rst_n;
    in_item_t  in;
    logic      in_valid;
    logic      in_ready;
    out_item_t out;
    logic      out_valid;
    logic      out_ready;
    int        fail_count;
    int        pending;
    int        result_count;
    int        cycle;
    int        sent;
    logic      calm;

    coalescing_command_write_buffer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out       (out),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    ccwb_tb_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in           (in),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out          (out),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("FAIL");
            $finish;
        end
    end

    // receiver stalls at random, except in the calm stretch
    always @(negedge clk)
    begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // called at a falling edge; valid stays up from one transaction to the
    // next unless an idle gap is drawn
    task automatic send_command(input logic [1:0] c, input logic [7:0] lba,
                                input logic [31:0] d, input logic [3:0] sz);
        begin
            if (!calm && $urandom_range(99) < 8)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                while ($urandom_range(99) < 8) @(negedge clk);
            end
            in       <= {c, lba, d, sz};
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            @(negedge clk);
            sent++;
        end
    endtask

    task automatic send_random();
        int r;
        logic [7:0] lba;
        begin
            r   = $urandom_range(99);
            // mostly addresses in a narrow window so commands collide
            lba = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(40));
            if (r < 25)
                send_command(CMD_READ, lba, $urandom, 4'($urandom));
            else if (r < 55)
                send_command(CMD_WRITE, lba, $urandom, 4'($urandom));
            else if (r < 90)
                send_command(CMD_ERASE, lba, $urandom,
                             ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 6)));
            else
                send_command(CMD_FLUSH, 8'($urandom), $urandom, 4'($urandom));
        end
    endtask

    initial
    begin
        int i;
        rst_n     = 1'b0;
        in        = '0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        cycle     = 0;
        sent      = 0;
        calm      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty flush, reads, limits, merges, bad erases, a full buffer
        send_command(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 4'hF);
        send_command(CMD_READ, 8'd0, 0, 0);
        send_command(CMD_WRITE, 8'd0, 32'hFFFF_FFFF, 4'hF);
        send_command(CMD_WRITE, 8'd127, 32'h0000_0000, 0);
        send_command(CMD_WRITE, 8'd0, 32'hA5A5_5A5A, 0);
        send_command(CMD_READ, 8'd0, 0, 0);
        send_command(CMD_WRITE, 8'd128, 32'h1, 0);
        send_command(CMD_READ, 8'd255, 0, 0);
        send_command(CMD_ERASE, 8'd10, 0, 4'd0);
        send_command(CMD_ERASE, 8'd10, 0, 4'd11);
        send_command(CMD_ERASE, 8'd120, 0, 4'd9);
        send_command(CMD_ERASE, 8'd118, 0, 4'd10);
        send_command(CMD_ERASE, 8'd20, 0, 4'd3);
        send_command(CMD_ERASE, 8'd23, 0, 4'd4);
        send_command(CMD_ERASE, 8'd18, 0, 4'd2);
        send_command(CMD_ERASE, 8'd16, 0, 4'd10);
        send_command(CMD_READ, 8'd22, 0, 0);
        send_command(CMD_FLUSH, 0, 0, 0);
        for (i = 0; i < 10; i++)
            send_command(CMD_WRITE, 8'(i * 3), $urandom, 0);

        for (i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 150 && i < 220);
            send_random();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("%0d commands sent, %0d results checked (reads, inserts, merges, flushes)",
                 sent, result_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
